// ===== design/pnm_header_parser_defines.svh =====
// Assertion macros used by the header parser top level.
`ifndef PNM_HEADER_PARSER_DEFINES_SVH
`define PNM_HEADER_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define PNM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pnm header parser check failed");

// Antecedent implies consequent in the next cycle.
`define PNM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pnm header parser check failed");

`else

`define PNM_ASSERT_SAME(label, ante, cons)
`define PNM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== design/pnm_hdr_pkg.sv =====
// Shared types, constants and helper functions of the header parser.
`default_nettype none
package pnm_hdr_pkg;

  localparam int VALUE_BITS = 16;
  localparam int OUT_BITS   = 16;
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);

  localparam logic [7:0] CH_P       = 8'h50;
  localparam logic [7:0] CH_1       = 8'h31;
  localparam logic [7:0] CH_2       = 8'h32;
  localparam logic [7:0] CH_3       = 8'h33;
  localparam logic [7:0] CH_4       = 8'h34;
  localparam logic [7:0] CH_5       = 8'h35;
  localparam logic [7:0] CH_6       = 8'h36;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [15:0] MAGIC_COMPACT = 16'h2a17;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD    = 2'd1;
  localparam logic [1:0] ST_NO_MAX = 2'd2;

  localparam logic [2:0] FMT_P1      = 3'd0;
  localparam logic [2:0] FMT_P4      = 3'd1;
  localparam logic [2:0] FMT_COMPACT = 3'd2;
  localparam logic [2:0] FMT_P2      = 3'd3;
  localparam logic [2:0] FMT_P5      = 3'd4;
  localparam logic [2:0] FMT_P3      = 3'd5;
  localparam logic [2:0] FMT_P6      = 3'd6;

  // One classified input beat as it travels through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       sof;
    logic       eos;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_hash;
    logic       is_newline;
  } beat_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [2:0]          format;
    logic [OUT_BITS-1:0] width;
    logic [OUT_BITS-1:0] height;
    logic [OUT_BITS-1:0] maxval;
  } result_t;

  // Truncate or zero-extend a parsed value to the output field width.
  function automatic logic [OUT_BITS-1:0] to_out(input logic [VALUE_BITS-1:0] v);
    logic [VALUE_BITS+OUT_BITS-1:0] ext;
    ext = {{OUT_BITS{1'b0}}, v};
    return ext[OUT_BITS-1:0];
  endfunction

  // Saturate a raw 16-bit dimension to the value range.
  function automatic logic [OUT_BITS-1:0] fit_raw(input logic [OUT_BITS-1:0] h);
    logic [VALUE_BITS+OUT_BITS-1:0] ext;
    logic [VALUE_BITS+OUT_BITS-1:0] lim;
    ext = {{VALUE_BITS{1'b0}}, h};
    lim = {{OUT_BITS{1'b0}}, {VALUE_BITS{1'b1}}};
    if (ext > lim) begin
      ext = lim;
    end
    return ext[OUT_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/pnm_hdr_front.sv =====
// Front end: register each input beat and classify its byte.
`default_nettype none
module pnm_hdr_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              data_valid,
  output logic                   data_stall,
  input  wire logic [7:0]        data_byte,
  input  wire logic              start_of_file,
  input  wire logic              end_of_stream,
  input  wire logic              q_full,
  output logic                   beat_valid,
  output pnm_hdr_pkg::beat_t     beat
);

  logic load;
  logic beat_valid_next;
  pnm_hdr_pkg::beat_t beat_in;

  assign data_stall = beat_valid & q_full;
  assign load       = data_valid & ~data_stall;

  always_comb begin
    beat_in            = '0;
    beat_in.data       = data_byte;
    beat_in.sof        = start_of_file;
    beat_in.eos        = end_of_stream;
    beat_in.is_digit   = (data_byte >= pnm_hdr_pkg::CH_0) && (data_byte <= pnm_hdr_pkg::CH_9);
    beat_in.digit      = data_byte[3:0];
    beat_in.is_hash    = (data_byte == pnm_hdr_pkg::CH_HASH);
    beat_in.is_newline = (data_byte == pnm_hdr_pkg::CH_NEWLINE);
  end

  always_comb begin
    beat_valid_next = beat_valid;
    if (load) begin
      beat_valid_next = 1'b1;
    end else if (beat_valid && !q_full) begin
      beat_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else begin
      beat_valid <= beat_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat <= beat_in;
    end
  end

endmodule
`default_nettype wire

// ===== design/pnm_hdr_fifo.sv =====
// Short queue of classified beats between front and back end.
`default_nettype none
module pnm_hdr_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire pnm_hdr_pkg::beat_t wdata,
  input  wire logic               pop,
  output pnm_hdr_pkg::beat_t      rdata,
  output logic                    full,
  output logic                    empty
);

  pnm_hdr_pkg::beat_t entries [pnm_hdr_pkg::QDEPTH];
  logic [pnm_hdr_pkg::QPTR_BITS-1:0] wptr;
  logic [pnm_hdr_pkg::QPTR_BITS-1:0] rptr;
  logic [pnm_hdr_pkg::QPTR_BITS:0]   count;

  assign full  = (count == (pnm_hdr_pkg::QPTR_BITS+1)'(pnm_hdr_pkg::QDEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== design/pnm_hdr_back.sv =====
// Back end: header state machine and output register.
`default_nettype none
module pnm_hdr_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_empty,
  input  wire pnm_hdr_pkg::beat_t beat,
  output logic                    pop,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output pnm_hdr_pkg::result_t    res
);

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_MAGIC2 = 5'b00010,
    PH_TEXT   = 5'b00100,
    PH_RAW    = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  localparam int VB = pnm_hdr_pkg::VALUE_BITS;
  localparam int OB = pnm_hdr_pkg::OUT_BITS;

  phase_t                phase, phase_next;
  logic [7:0]            first_byte, first_byte_next;
  logic [2:0]            fmt, fmt_next;
  logic [VB-1:0]         acc, acc_next;
  logic                  in_num, in_num_next;
  logic                  in_cmt, in_cmt_next;
  logic [1:0]            fcnt, fcnt_next;
  logic [OB-1:0]         width_hold, width_hold_next;
  logic [OB-1:0]         height_hold, height_hold_next;
  logic [1:0]            raw_cnt, raw_cnt_next;
  logic                  emit;
  pnm_hdr_pkg::result_t  emit_res;
  logic                  out_free;
  logic [VB+3:0]         acc_ext;
  logic [VB+3:0]         acc_sum;
  logic [VB+3:0]         acc_lim;
  logic [VB-1:0]         acc_sat;

  assign out_free = ~res_valid | ~res_stall;
  assign pop      = ~q_empty & out_free;

  // Multiply by ten as shift and add, then clamp.
  always_comb begin
    acc_ext = {4'b0, acc};
    acc_sum = (acc_ext << 3) + (acc_ext << 1) + {{VB{1'b0}}, beat.digit};
    acc_lim = {4'b0, {VB{1'b1}}};
    acc_sat = (acc_sum > acc_lim) ? {VB{1'b1}} : acc_sum[VB-1:0];
  end

  always_comb begin
    phase_next       = phase;
    first_byte_next  = first_byte;
    fmt_next         = fmt;
    acc_next         = acc;
    in_num_next      = in_num;
    in_cmt_next      = in_cmt;
    fcnt_next        = fcnt;
    width_hold_next  = width_hold;
    height_hold_next = height_hold;
    raw_cnt_next     = raw_cnt;
    emit             = 1'b0;
    emit_res         = '0;
    emit_res.status  = pnm_hdr_pkg::ST_BAD;

    if (beat.sof) begin
      fmt_next         = '0;
      acc_next         = '0;
      in_num_next      = 1'b0;
      in_cmt_next      = 1'b0;
      fcnt_next        = '0;
      width_hold_next  = '0;
      height_hold_next = '0;
      raw_cnt_next     = '0;
      first_byte_next  = beat.data;
      if (beat.eos) begin
        emit = 1'b1;
      end else begin
        phase_next = PH_MAGIC2;
      end
    end else if (beat.eos) begin
      case (phase)
        PH_MAGIC2: emit = 1'b1;
        PH_TEXT: begin
          emit = 1'b1;
          emit_res.format = fmt;
          if (fcnt >= 2'd2) begin
            emit_res.status = pnm_hdr_pkg::ST_NO_MAX;
            emit_res.width  = width_hold;
            emit_res.height = height_hold;
          end
        end
        PH_RAW: begin
          emit = 1'b1;
          emit_res.format = fmt;
        end
        default: emit = 1'b0;
      endcase
    end else begin
      case (phase)
        PH_MAGIC2: begin
          if ({first_byte, beat.data} == pnm_hdr_pkg::MAGIC_COMPACT) begin
            fmt_next   = pnm_hdr_pkg::FMT_COMPACT;
            phase_next = PH_RAW;
          end else if (first_byte == pnm_hdr_pkg::CH_P) begin
            phase_next = PH_TEXT;
            case (beat.data)
              pnm_hdr_pkg::CH_1: fmt_next = pnm_hdr_pkg::FMT_P1;
              pnm_hdr_pkg::CH_4: fmt_next = pnm_hdr_pkg::FMT_P4;
              pnm_hdr_pkg::CH_2: fmt_next = pnm_hdr_pkg::FMT_P2;
              pnm_hdr_pkg::CH_5: fmt_next = pnm_hdr_pkg::FMT_P5;
              pnm_hdr_pkg::CH_3: fmt_next = pnm_hdr_pkg::FMT_P3;
              pnm_hdr_pkg::CH_6: fmt_next = pnm_hdr_pkg::FMT_P6;
              default: begin
                emit       = 1'b1;
                phase_next = phase;
              end
            endcase
          end else begin
            emit = 1'b1;
          end
        end
        PH_RAW: begin
          if (raw_cnt < 2'd2) begin
            width_hold_next = {width_hold[7:0], beat.data};
          end else begin
            height_hold_next = {height_hold[7:0], beat.data};
          end
          raw_cnt_next = raw_cnt + 2'd1;
          if (raw_cnt == 2'd3) begin
            emit            = 1'b1;
            emit_res.status = pnm_hdr_pkg::ST_OK;
            emit_res.format = pnm_hdr_pkg::FMT_COMPACT;
            emit_res.width  = pnm_hdr_pkg::fit_raw(width_hold_next);
            emit_res.height = pnm_hdr_pkg::fit_raw(height_hold_next);
            emit_res.maxval = OB'(1);
          end
        end
        PH_TEXT: begin
          if (in_cmt) begin
            if (beat.is_newline) begin
              in_cmt_next = 1'b0;
            end
          end else if (beat.is_digit) begin
            acc_next    = acc_sat;
            in_num_next = 1'b1;
          end else begin
            if (beat.is_hash) begin
              in_cmt_next = 1'b1;
            end
            if (in_num) begin
              in_num_next = 1'b0;
              acc_next    = '0;
              case (fcnt)
                2'd0: begin
                  width_hold_next = pnm_hdr_pkg::to_out(acc);
                  fcnt_next       = 2'd1;
                end
                2'd1: begin
                  height_hold_next = pnm_hdr_pkg::to_out(acc);
                  fcnt_next        = 2'd2;
                  if (fmt <= pnm_hdr_pkg::FMT_P4) begin
                    emit            = 1'b1;
                    emit_res.status = pnm_hdr_pkg::ST_OK;
                    emit_res.format = fmt;
                    emit_res.width  = width_hold;
                    emit_res.height = pnm_hdr_pkg::to_out(acc);
                    emit_res.maxval = OB'(1);
                  end
                end
                default: begin
                  emit            = 1'b1;
                  emit_res.status = pnm_hdr_pkg::ST_OK;
                  emit_res.format = fmt;
                  emit_res.width  = width_hold;
                  emit_res.height = height_hold;
                  emit_res.maxval = pnm_hdr_pkg::to_out(acc);
                end
              endcase
            end
          end
        end
        default: emit = 1'b0;
      endcase
    end

    if (emit) begin
      phase_next = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      first_byte  <= '0;
      fmt         <= '0;
      acc         <= '0;
      in_num      <= 1'b0;
      in_cmt      <= 1'b0;
      fcnt        <= '0;
      width_hold  <= '0;
      height_hold <= '0;
      raw_cnt     <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (pop) begin
        phase       <= phase_next;
        first_byte  <= first_byte_next;
        fmt         <= fmt_next;
        acc         <= acc_next;
        in_num      <= in_num_next;
        in_cmt      <= in_cmt_next;
        fcnt        <= fcnt_next;
        width_hold  <= width_hold_next;
        height_hold <= height_hold_next;
        raw_cnt     <= raw_cnt_next;
      end
      if (pop && emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res <= emit_res;
    end
  end

endmodule
`default_nettype wire

// ===== design/pnm_header_parser.sv =====
// Top level of the portable bitmap/graymap/pixmap header parser.
// A beat that ends a header passes through the front register and the queue before its result is registered.
// Throughput: one beat per cycle while the queue has room; the back end consumes a queued
//   beat each cycle its output register is free, and a four-entry queue absorbs result stalls.
// Reset (rst, synchronous, active high) empties the queue and output register
//   and returns the parser to idle, waiting for a start-of-file beat.
`default_nettype none
`include "pnm_header_parser_defines.svh"
module pnm_header_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  // input beats
  input  wire logic        data_valid,
  output logic             data_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        start_of_file,
  input  wire logic        end_of_stream,
  // result beats
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [1:0]       status,
  output logic [2:0]       format,
  output logic [15:0]      image_width,
  output logic [15:0]      image_height,
  output logic [15:0]      max_value
);

  // Front end: classified beat waiting to enter the queue.
  logic                 front_valid;
  pnm_hdr_pkg::beat_t   front_beat;

  // Queue status and head beat.
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  pnm_hdr_pkg::beat_t   q_head;

  pnm_hdr_pkg::result_t res;

  // Result beat classification for the checks below.
  logic                 bitmap_ok;
  logic                 dims_zero;

  pnm_hdr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .data_valid    (data_valid),
    .data_stall    (data_stall),
    .data_byte     (data_byte),
    .start_of_file (start_of_file),
    .end_of_stream (end_of_stream),
    .q_full        (q_full),
    .beat_valid    (front_valid),
    .beat          (front_beat)
  );

  // Hand the front beat over whenever the queue has room.
  pnm_hdr_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid & ~q_full),
    .wdata (front_beat),
    .pop   (q_pop),
    .rdata (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back end advances the header state and drops results into its output register.
  pnm_hdr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .beat      (q_head),
    .pop       (q_pop),
    .res_valid (result_valid),
    .res_stall (result_stall),
    .res       (res)
  );

  assign status       = res.status;
  assign format       = res.format;
  assign image_width  = res.width;
  assign image_height = res.height;
  assign max_value    = res.maxval;

  assign bitmap_ok = result_valid && (status == pnm_hdr_pkg::ST_OK) &&
                     ((format == pnm_hdr_pkg::FMT_P1) || (format == pnm_hdr_pkg::FMT_P4) ||
                      (format == pnm_hdr_pkg::FMT_COMPACT));
  assign dims_zero = (image_width == 16'd0) && (image_height == 16'd0) &&
                     (max_value == 16'd0);

  // Stalling the input only ever happens with a beat held in the front register.
  `PNM_ASSERT_SAME(a_stall_has_beat, data_stall, front_valid && q_full)
  // Bitmap headers that complete carry a maxval of one.
  `PNM_ASSERT_SAME(a_bitmap_max, bitmap_ok, max_value == 16'd1)
  // Errors report zero dimensions.
  `PNM_ASSERT_SAME(a_bad_zero, result_valid && status == pnm_hdr_pkg::ST_BAD, dims_zero)
  // Pop only from a queue that holds a beat.
  `PNM_ASSERT_SAME(a_pop_not_empty, q_pop, !q_empty)

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the PNM header parser: scripted beats, then random files.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pnm_hdr_pkg::*;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam int unsigned VALUE_MAX = (1 << VALUE_BITS) - 1;

  // Where the tracking parser stands within the current file.
  typedef enum logic [2:0] {
    AWAIT_START,
    AWAIT_MAGIC2,
    TEXT_FIELDS,
    RAW_DIMS,
    HEADER_DONE
  } parse_phase_e;

  // One scripted beat; a pinned row carries the header it must produce.
  typedef struct packed {
    logic [7:0] b;
    logic       sof;
    logic       eos;
    logic       pinned;
    result_t    want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        data_valid = 1'b0;
  logic        data_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        start_of_file = 1'b0;
  logic        end_of_stream = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [1:0]  status;
  logic [2:0]  format;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [15:0] max_value;

  // Header fields still owed by the parser, oldest first.
  result_t expected_headers[$];
  // Bytes of the random file being assembled.
  logic [7:0] file_bytes[$];

  int mismatches = 0;
  int beats_sent = 0;
  int headers_owed = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  // Tracking copy of the parser state.
  parse_phase_e hp_phase = AWAIT_START;
  logic [7:0]   magic_hi = 8'h00;
  logic [2:0]   fmt_kind = FMT_P1;
  logic [15:0]  acc = 16'd0;
  logic         in_number = 1'b0;
  logic         in_comment = 1'b0;
  logic [1:0]   fields_done = 2'd0;
  logic [15:0]  width_seen = 16'd0;
  logic [15:0]  height_seen = 16'd0;
  logic [1:0]   raw_count = 2'd0;

  // Directed part: extremes, error paths, comment handling, abort and
  // the ignored beats either side of a file.
  script_row_t script [25] = '{
    '{8'h41, 1'b0, 1'b0, 1'b0, '0},                       // stray byte before any start
    '{8'h00, 1'b0, 1'b1, 1'b0, '0},                       // end of stream while idle
    '{8'hff, 1'b1, 1'b1, 1'b1,                            // start and end together
      '{ST_BAD, FMT_P1, 16'd0, 16'd0, 16'd0}},
    '{8'h00, 1'b0, 1'b1, 1'b0, '0},                       // end after a result
    '{8'h58, 1'b1, 1'b0, 1'b0, '0},                       // unknown magic
    '{8'h00, 1'b0, 1'b0, 1'b1, '{ST_BAD, FMT_P1, 16'd0, 16'd0, 16'd0}},
    '{MAGIC_COMPACT[15:8], 1'b1, 1'b0, 1'b0, '0},         // compact bitmap
    '{MAGIC_COMPACT[7:0], 1'b0, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, 1'b1, '{ST_OK, FMT_COMPACT, 16'hffff, 16'd1, 16'd1}},
    '{8'h5a, 1'b0, 1'b0, 1'b0, '0},                       // byte after a result
    '{CH_P, 1'b1, 1'b0, 1'b0, '0},                        // P3 begun, then abandoned
    '{CH_3, 1'b0, 1'b0, 1'b0, '0},
    '{CH_P, 1'b1, 1'b0, 1'b0, '0},                        // P2 restarts the parser
    '{CH_2, 1'b0, 1'b0, 1'b0, '0},
    '{CH_9, 1'b0, 1'b0, 1'b0, '0},
    '{CH_HASH, 1'b0, 1'b0, 1'b0, '0},                     // ends the width, opens a comment
    '{CH_5, 1'b0, 1'b0, 1'b0, '0},
    '{CH_NEWLINE, 1'b0, 1'b0, 1'b0, '0},
    '{CH_0, 1'b0, 1'b0, 1'b0, '0},
    '{CH_SPACE, 1'b0, 1'b0, 1'b0, '0},
    '{CH_4, 1'b0, 1'b0, 1'b0, '0},                        // maxval digit, never ended
    '{8'h00, 1'b0, 1'b1, 1'b1, '{ST_NO_MAX, FMT_P2, 16'd9, 16'd0, 16'd0}}
  };

  pnm_header_parser dut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_byte    (data_byte),
    .start_of_file(start_of_file),
    .end_of_stream(end_of_stream),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .format       (format),
    .image_width  (image_width),
    .image_height (image_height),
    .max_value    (max_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Close the current file with a header and park the tracker until the next start.
  function automatic result_t close_header(input logic [1:0] st, input logic [2:0] fmt,
                                           input logic [15:0] w, input logic [15:0] h,
                                           input logic [15:0] m);
    hp_phase = HEADER_DONE;
    return '{status: st, format: fmt, width: w, height: h, maxval: m};
  endfunction

  // Advance the tracker by one accepted beat; return 1 when a header falls out.
  function automatic bit parse_header_byte(input logic [7:0] b, input logic sof,
                                           input logic eos, output result_t hdr);
    bit          made;
    int unsigned grown;
    logic [15:0] v;
    made = 1'b0;
    hdr  = '0;
    if (sof) begin
      // A start always wins: wipe the file in progress and take the first magic byte.
      fmt_kind    = FMT_P1;
      acc         = 16'd0;
      in_number   = 1'b0;
      in_comment  = 1'b0;
      fields_done = 2'd0;
      width_seen  = 16'd0;
      height_seen = 16'd0;
      raw_count   = 2'd0;
      magic_hi    = b;
      if (eos) begin
        hdr  = close_header(ST_BAD, FMT_P1, 16'd0, 16'd0, 16'd0);
        made = 1'b1;
      end else begin
        hp_phase = AWAIT_MAGIC2;
      end
    end else if (eos) begin
      case (hp_phase)
        AWAIT_MAGIC2: begin
          hdr  = close_header(ST_BAD, FMT_P1, 16'd0, 16'd0, 16'd0);
          made = 1'b1;
        end
        TEXT_FIELDS: begin
          if (fields_done >= 2'd2) begin
            hdr = close_header(ST_NO_MAX, fmt_kind, width_seen, height_seen, 16'd0);
          end else begin
            hdr = close_header(ST_BAD, fmt_kind, 16'd0, 16'd0, 16'd0);
          end
          made = 1'b1;
        end
        RAW_DIMS: begin
          hdr  = close_header(ST_BAD, fmt_kind, 16'd0, 16'd0, 16'd0);
          made = 1'b1;
        end
        default: ;
      endcase
    end else begin
      case (hp_phase)
        AWAIT_MAGIC2: begin
          if ({magic_hi, b} == MAGIC_COMPACT) begin
            fmt_kind = FMT_COMPACT;
            hp_phase = RAW_DIMS;
          end else if (magic_hi == CH_P && b >= CH_1 && b <= CH_6) begin
            case (b)
              CH_1:    fmt_kind = FMT_P1;
              CH_4:    fmt_kind = FMT_P4;
              CH_2:    fmt_kind = FMT_P2;
              CH_5:    fmt_kind = FMT_P5;
              CH_3:    fmt_kind = FMT_P3;
              default: fmt_kind = FMT_P6;
            endcase
            hp_phase = TEXT_FIELDS;
          end else begin
            hdr  = close_header(ST_BAD, FMT_P1, 16'd0, 16'd0, 16'd0);
            made = 1'b1;
          end
        end
        RAW_DIMS: begin
          if (raw_count < 2'd2) begin
            width_seen = {width_seen[7:0], b};
          end else begin
            height_seen = {height_seen[7:0], b};
          end
          if (raw_count == 2'd3) begin
            raw_count = 2'd0;
            hdr  = close_header(ST_OK, FMT_COMPACT, width_seen, height_seen, 16'd1);
            made = 1'b1;
          end else begin
            raw_count = raw_count + 2'd1;
          end
        end
        TEXT_FIELDS: begin
          if (in_comment) begin
            if (b == CH_NEWLINE) in_comment = 1'b0;
          end else if (b >= CH_0 && b <= CH_9) begin
            grown     = acc * 10 + (b - CH_0);
            acc       = (grown > VALUE_MAX) ? 16'(VALUE_MAX) : grown[15:0];
            in_number = 1'b1;
          end else begin
            if (b == CH_HASH) in_comment = 1'b1;
            if (in_number) begin
              in_number = 1'b0;
              v         = acc;
              acc       = 16'd0;
              case (fields_done)
                2'd0: begin
                  width_seen  = v;
                  fields_done = 2'd1;
                end
                2'd1: begin
                  height_seen = v;
                  fields_done = 2'd2;
                  if (fmt_kind == FMT_P1 || fmt_kind == FMT_P4) begin
                    hdr  = close_header(ST_OK, fmt_kind, width_seen, height_seen, 16'd1);
                    made = 1'b1;
                  end
                end
                default: begin
                  hdr  = close_header(ST_OK, fmt_kind, width_seen, height_seen, v);
                  made = 1'b1;
                end
              endcase
            end
          end
        end
        default: ;
      endcase
    end
    return made;
  endfunction

  // Present one beat from a falling edge, hold it through stalls, and book
  // its header once the rising edge takes it.
  task automatic send_beat(input logic [7:0] b, input logic sof, input logic eos,
                           input bit pinned, input result_t pinned_hdr);
    result_t hdr;
    while ($urandom_range(0, 99) < gap_pct) begin
      data_valid <= 1'b0;
      @(negedge clk);
    end
    data_valid    <= 1'b1;
    data_byte     <= b;
    start_of_file <= sof;
    end_of_stream <= eos;
    @(posedge clk);
    while (data_stall) @(posedge clk);
    beats_sent++;
    if (parse_header_byte(b, sof, eos, hdr)) begin
      expected_headers.push_back(pinned ? pinned_hdr : hdr);
      headers_owed++;
    end
    @(negedge clk);
  endtask

  // Drop valid and hold the sender until every owed header has been taken.
  task automatic hold_until_drained();
    data_valid <= 1'b0;
    while (expected_headers.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Whitespace, stray non-digits and the odd comment between fields.
  function automatic void push_gap();
    int         n;
    logic [7:0] c;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          file_bytes.push_back(CH_HASH);
          repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom_range(0, 255)));
          file_bytes.push_back(CH_NEWLINE);
        end
        1, 2: begin
          do c = 8'($urandom_range(0, 255)); while (c >= CH_0 && c <= CH_9);
          file_bytes.push_back(c);
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       c = CH_SPACE;
            1:       c = 8'h09;
            2:       c = CH_NEWLINE;
            default: c = 8'h0d;
          endcase
          file_bytes.push_back(c);
        end
      endcase
    end
  endfunction

  // Mostly short numbers; now and then one at or past the saturation point.
  function automatic void push_number();
    int    r;
    int    digits;
    string txt;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      txt = $urandom_range(0, 1) ? "65535" : "65536";
      for (int i = 0; i < txt.len(); i++) file_bytes.push_back(txt[i]);
    end else begin
      if (r < 4) digits = $urandom_range(5, 6);
      else if (r < 10) digits = $urandom_range(3, 4);
      else digits = $urandom_range(1, 2);
      repeat (digits) file_bytes.push_back(CH_0 + 8'($urandom_range(0, 9)));
    end
  endfunction

  // Build one file and send it whole, cut short, abandoned, or replace it by noise.
  task automatic send_random_file();
    int         pick;
    int         shape;
    int         fields;
    int         cut;
    logic [7:0] c;
    file_bytes.delete();
    pick = $urandom_range(0, 7);
    if (pick < 6) begin
      file_bytes.push_back(CH_P);
      case (pick)
        0:       c = CH_1;
        1:       c = CH_4;
        2:       c = CH_2;
        3:       c = CH_5;
        4:       c = CH_3;
        default: c = CH_6;
      endcase
      file_bytes.push_back(c);
      fields = (pick < 2) ? 2 : 3;
      if ($urandom_range(0, 7) == 0) fields++;
      if ($urandom_range(0, 3) != 0) push_gap();
      repeat (fields) begin
        push_number();
        push_gap();
      end
    end else if (pick == 6) begin
      file_bytes.push_back(MAGIC_COMPACT[15:8]);
      file_bytes.push_back(MAGIC_COMPACT[7:0]);
      repeat (4) begin
        case ($urandom_range(0, 7))
          0:       file_bytes.push_back(8'h00);
          1:       file_bytes.push_back(8'hff);
          default: file_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      file_bytes.push_back($urandom_range(0, 1) ? CH_P : 8'($urandom_range(0, 255)));
      file_bytes.push_back(8'($urandom_range(0, 255)));
    end

    shape = $urandom_range(0, 99);
    cut   = $urandom_range(1, file_bytes.size() - 1);
    if (shape < 65) begin
      foreach (file_bytes[i]) send_beat(file_bytes[i], i == 0, 1'b0, 1'b0, '0);
      // Trailing bytes and a late end of stream must be swallowed.
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3))
          send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
      end
      if ($urandom_range(0, 4) < 2) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
    end else if (shape < 92) begin
      for (int i = 0; i < cut; i++) send_beat(file_bytes[i], i == 0, 1'b0, 1'b0, '0);
      // Either end the stream early, or leave the file for the next start to abort.
      if (shape < 80) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
    end else begin
      repeat ($urandom_range(1, 6)) begin
        send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                  $urandom_range(0, 7) == 0, 1'b0, '0);
      end
    end
  endtask

  // Receiver side: pick the stall for the coming edge on each falling edge.
  always @(negedge clk) begin
    result_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every header taken at a rising edge against the oldest one owed.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_headers.size() == 0) begin
        $error("header beat with nothing owed: status %0d format %0d", status, format);
        mismatches++;
      end else begin
        want = expected_headers.pop_front();
        check_field("status", 16'(want.status), 16'(status));
        check_field("format", 16'(want.format), 16'(format));
        check_field("image_width", want.width, image_width);
        check_field("image_height", want.height, image_height);
        check_field("max_value", want.maxval, max_value);
      end
    end
  end

  initial begin
    int start_beats;
    int start_headers;
    // Hold reset, then release it on a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Scripted beats under light sender gaps and heavy result stalls.
    gap_pct   = 22;
    stall_pct = 57;
    foreach (script[i]) begin
      send_beat(script[i].b, script[i].sof, script[i].eos, script[i].pinned, script[i].want);
    end
    hold_until_drained();

    // Random files in three idling regimes: sender-light, receiver-light, none.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          gap_pct   = 22;
          stall_pct = 57;
        end
        1: begin
          gap_pct   = 57;
          stall_pct = 22;
        end
        default: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
      endcase
      start_beats   = beats_sent;
      start_headers = headers_owed;
      while (beats_sent - start_beats < 217 || headers_owed - start_headers < 15) begin
        send_random_file();
      end
      hold_until_drained();
    end

    // Let anything stray surface before the verdict.
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #3ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+design
design/pnm_hdr_pkg.sv
design/pnm_hdr_front.sv
design/pnm_hdr_fifo.sv
design/pnm_hdr_back.sv
design/pnm_header_parser.sv
tb/sv/tb.sv
